[src/scu_pkg.sv]
// ----------------------------------------------------------------------------
// scu_pkg: shared definitions for the sine/cosine Taylor series unit
// Holds fixed-point formats, reduction constants, the coefficient table
// and the rounding Q30 multiply used by the series pipeline.
// ----------------------------------------------------------------------------
package scu_pkg;

  // Series length and angle format.
  localparam int NUM_TERMS       = 9;
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int RED_FRAC        = 44;

  // Width of the series accumulator; the sums stay below 2^35 in magnitude.
  localparam int ACC_W = 40;

  // Range reduction constants at 44 fraction bits.
  localparam logic signed [63:0] PI_Q44     = 64'sh0000_3243_F6A8_885A;
  localparam logic signed [63:0] TWO_PI_Q44 = 64'sh0000_6487_ED51_10B4;

  // Reciprocal of 2*pi scaled by 2^32, used to estimate the turn count.
  localparam logic [29:0] RECIP_2PI = 30'd683565276;
  localparam int K_W = 16;

  // Queue between the front and the back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic signed [ACC_W-1:0] acc_t;

  // Reduced work item passed from the front to the back.
  typedef struct packed {
    logic              cmd;
    logic signed [31:0] y;
  } scu_item_t;

  // Operand clamps of the Q30 multiply.
  localparam logic [ACC_W-1:0] LIM_A = ACC_W'((64'd1 << 34) - 64'd1);
  localparam logic [ACC_W-1:0] LIM_B = ACC_W'((64'd1 << 30) - 64'd1);

  // Coefficients 4^n/n! in Q30.
  function automatic logic [33:0] coef_mag(input logic [4:0] idx);
    logic [33:0] v;
    unique case (idx)
      5'd0:    v = 34'd1073741824;
      5'd1:    v = 34'd4294967296;
      5'd2:    v = 34'd8589934592;
      5'd3:    v = 34'd11453246123;
      5'd4:    v = 34'd11453246123;
      5'd5:    v = 34'd9162596898;
      5'd6:    v = 34'd6108397932;
      5'd7:    v = 34'd3490513104;
      5'd8:    v = 34'd1745256552;
      5'd9:    v = 34'd775669579;
      5'd10:   v = 34'd310267831;
      5'd11:   v = 34'd112824666;
      5'd12:   v = 34'd37608222;
      5'd13:   v = 34'd11571761;
      5'd14:   v = 34'd3306217;
      5'd15:   v = 34'd881658;
      5'd16:   v = 34'd220414;
      5'd17:   v = 34'd51862;
      5'd18:   v = 34'd11525;
      5'd19:   v = 34'd2426;
      5'd20:   v = 34'd485;
      5'd21:   v = 34'd92;
      5'd22:   v = 34'd17;
      5'd23:   v = 34'd3;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Signed coefficient of series term; cmd low picks the odd (sine) powers.
  function automatic acc_t signed_coef(input int term, input logic cmd);
    logic [4:0] idx;
    acc_t       v;
    idx = cmd ? 5'(2 * term) : 5'(2 * term + 1);
    v   = acc_t'({{(ACC_W-34){1'b0}}, coef_mag(idx)});
    return term[0] ? -v : v;
  endfunction

  // Q30 product with clamped operands, magnitude rounded half up.
  function automatic acc_t qmul(input acc_t a, input acc_t b);
    logic             neg;
    logic [ACC_W-1:0] ma;
    logic [ACC_W-1:0] mb;
    logic [33:0]      ca;
    logic [29:0]      cb;
    logic [63:0]      p;
    acc_t             pm;
    neg = a[ACC_W-1] ^ b[ACC_W-1];
    ma  = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    mb  = b[ACC_W-1] ? ACC_W'(-b) : ACC_W'(b);
    ca  = (ma > LIM_A) ? '1 : ma[33:0];
    cb  = (mb > LIM_B) ? '1 : mb[29:0];
    p   = 64'(ca) * 64'(cb) + (64'd1 << 29);
    pm  = acc_t'({{(ACC_W-34){1'b0}}, p[63:30]});
    return neg ? -pm : pm;
  endfunction

endpackage

[src/scu_front.sv]
// ----------------------------------------------------------------------------
// scu_front: angle range reduction
// Takes input words, reduces the angle into [-pi, pi) and scales it to
// y = x/4 in Q30, then pushes the reduced word into the queue.
// ----------------------------------------------------------------------------
module scu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic signed [31:0]  angle_i,
  output logic                push_o,
  output scu_pkg::scu_item_t  push_item_o,
  input  logic                full_i
);

  localparam int F = scu_pkg::ANGLE_FRAC_BITS;

  logic en;

  logic                v1_q, v2_q, v3_q;
  logic                cmd1_q, cmd2_q;
  logic signed [31:0]  a1_q;
  logic signed [55:0]  prod1_q;
  logic signed [63:0]  s2_q, kp2_q;
  scu_pkg::scu_item_t  item3_q;

  logic signed [23:0]       t_in;
  logic signed [55:0]       prod_d;
  logic signed [55:0]       kr;
  logic signed [scu_pkg::K_W-1:0] k;
  logic signed [63:0]       s_d, kp_d;
  logic signed [63:0]       r0, r, z, yw;

  // The whole front advances unless its last word is blocked by a full queue.
  assign en          = !(v3_q && full_i);
  assign in_ready_o  = en;
  assign push_o      = v3_q && !full_i;
  assign push_item_o = item3_q;

  // Turn count estimate: top angle bits times the reciprocal of 2*pi.
  always_comb begin
    t_in   = angle_i[31:8];
    prod_d = 56'(t_in) * 56'(signed'({1'b0, scu_pkg::RECIP_2PI}));
  end

  // Estimated turn count and the multiple of 2*pi to take away.
  always_comb begin
    kr   = (prod1_q + (56'sd1 <<< (F + 23))) >>> (F + 24);
    k    = kr[scu_pkg::K_W-1:0];
    s_d  = (64'(a1_q) <<< (scu_pkg::RED_FRAC - F)) + scu_pkg::PI_Q44;
    kp_d = 64'(k) * scu_pkg::TWO_PI_Q44;
  end

  // Remainder with a single correction step, then shift to Q30 with rounding.
  always_comb begin
    r0 = s2_q - kp2_q;
    if (r0 < 0) begin
      r = r0 + scu_pkg::TWO_PI_Q44;
    end else if (r0 >= scu_pkg::TWO_PI_Q44) begin
      r = r0 - scu_pkg::TWO_PI_Q44;
    end else begin
      r = r0;
    end
    z  = r - scu_pkg::PI_Q44;
    yw = (z + 64'sd32768) >>> 16;
  end

  // Valid bits of the three front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q       <= command_i;
      a1_q         <= angle_i;
      prod1_q      <= prod_d;
      cmd2_q       <= cmd1_q;
      s2_q         <= s_d;
      kp2_q        <= kp_d;
      item3_q.cmd  <= cmd2_q;
      item3_q.y    <= yw[31:0];
    end
  end

endmodule

[src/scu_fifo.sv]
// ----------------------------------------------------------------------------
// scu_fifo: short queue between front and back
// A small register queue that lets the reduction and the series stall
// independently of each other.
// ----------------------------------------------------------------------------
module scu_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  scu_pkg::scu_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output scu_pkg::scu_item_t pop_item_o,
  output logic               empty_o
);

  scu_pkg::scu_item_t mem_q [scu_pkg::FIFO_DEPTH];

  logic [scu_pkg::FIFO_AW-1:0] wr_q, rd_q;
  logic [scu_pkg::FIFO_AW:0]   count_q;

  assign full_o     = (count_q == (scu_pkg::FIFO_AW+1)'(scu_pkg::FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not follow a write");
`endif

endmodule

[src/scu_back.sv]
// ----------------------------------------------------------------------------
// scu_back: Horner series pipeline
// Squares the reduced angle, runs one Horner step per stage and applies
// the final sine multiply and saturation into the output register.
// ----------------------------------------------------------------------------
module scu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  output logic               pop_o,
  input  scu_pkg::scu_item_t pop_item_i,
  input  logic               empty_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o
);

  localparam int N = scu_pkg::NUM_TERMS;

  logic en;

  logic          v_q   [N];
  logic          cmd_q [N];
  scu_pkg::acc_t y_q   [N];
  scu_pkg::acc_t w_q   [N];
  scu_pkg::acc_t acc_q [N];

  logic               out_v_q;
  logic signed [31:0] value_q;

  scu_pkg::acc_t y_in;
  scu_pkg::acc_t res;

  // The pipeline moves unless the output word is waiting on the receiver.
  assign en          = !(out_v_q && !out_ready_i);
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_v_q;
  assign value_o     = value_q;
  assign y_in        = scu_pkg::ACC_W'(pop_item_i.y);

  // Stage 0: square of the reduced angle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_q[0] <= pop_item_i.cmd;
      y_q[0]   <= y_in;
      w_q[0]   <= scu_pkg::qmul(y_in, y_in);
      acc_q[0] <= '0;
    end
  end

  // One Horner step per stage, from the highest term down.
  for (genvar j = 1; j < N; j++) begin : g_step
    scu_pkg::acc_t prev;
    scu_pkg::acc_t nxt;

    always_comb begin
      if (j == 1) begin
        prev = scu_pkg::signed_coef(N - 1, cmd_q[j-1]);
      end else begin
        prev = acc_q[j-1];
      end
      nxt = scu_pkg::signed_coef(N - 1 - j, cmd_q[j-1]) +
            scu_pkg::qmul(prev, w_q[j-1]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cmd_q[j] <= cmd_q[j-1];
        y_q[j]   <= y_q[j-1];
        w_q[j]   <= w_q[j-1];
        acc_q[j] <= nxt;
      end
    end
  end

  // Final sine multiply and saturation to Q1.30.
  always_comb begin
    res = cmd_q[N-1] ? acc_q[N-1] : scu_pkg::qmul(acc_q[N-1], y_q[N-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (res > scu_pkg::acc_t'(32'sh7FFF_FFFF)) begin
        value_q <= 32'sh7FFF_FFFF;
      end else if (res < scu_pkg::acc_t'(-33'sh0_8000_0000)) begin
        value_q <= 32'sh8000_0000;
      end else begin
        value_q <= res[31:0];
      end
    end
  end

endmodule

[src/sine_cosine_taylor_unit.sv]
// ----------------------------------------------------------------------------
// sine_cosine_taylor_unit: fixed-point sine and cosine by Taylor series
//
// Input channel (in_valid_i / in_ready_o) takes one word per handshake:
// command_i selects sine (0) or cosine (1), angle_i is radians with 24
// fraction bits. Output channel (out_valid_o / out_ready_i) returns one
// word per input word, value_o in signed Q1.30, saturated.
// A three-stage front reduces the angle into [-pi, pi); a four-entry queue
// feeds the back, which squares the angle, runs one Horner step per stage
// and multiplies by the angle for sine.
// Throughput is one word per cycle while out_ready_i stays high. A word passes
// through three front stages, the queue and ten series stages including the
// output register.
// Reset clears all valid flags and the queue; no word is in flight after it.
// When the receiver holds out_ready_i low, the back pipeline freezes, the
// queue fills, and then the front stops and drops in_ready_o.
// ----------------------------------------------------------------------------
module sine_cosine_taylor_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic signed [31:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o
);

  logic               push, pop, full, empty;
  scu_pkg::scu_item_t push_item, pop_item;

  // Range reduction.
  scu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .angle_i     (angle_i),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  // Decoupling queue.
  scu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .empty_o     (empty)
  );

  // Series evaluation.
  scu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .pop_item_i  (pop_item),
    .empty_i     (empty),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o)
  );

endmodule

[dv/tb_sine_cosine_taylor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sine_cosine_taylor_unit: self-checking bench for the Taylor series unit
// Drives angle and command words through the valid/ready input, predicts each
// sine or cosine value in Q1.30 with an independent fixed-point model, and
// compares every returned word in order. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_sine_cosine_taylor_unit;

  localparam int TERMS      = 9;
  localparam int WATCH_LIM  = 2000;
  localparam int N_RANDOM   = 1850;
  localparam logic signed [63:0] PI44  = 64'sh0000_3243_F6A8_885A;
  localparam logic signed [63:0] TPI44 = 64'sh0000_6487_ED51_10B4;
  localparam logic CMD_SINE = 1'b0;
  localparam logic CMD_COSINE = 1'b1;

  // Reciprocal factorial table 4^n/n! in Q30, built at start.
  logic [63:0] fact_tab [2*TERMS];

  function automatic void build_fact_tab();
    logic [63:0] c;
    c = 64'd1 << 60;
    fact_tab[0] = (c + (64'd1 << 29)) >> 30;
    for (int n = 1; n < 2*TERMS; n++) begin
      c = 4 * (c / n) + (4 * (c % n)) / n;
      fact_tab[n] = (c + (64'd1 << 29)) >> 30;
    end
  endfunction

  // Rounding Q30 product with clamped operand magnitudes.
  function automatic longint mul_q30(longint a, longint b);
    logic neg;
    logic [63:0] ma, mb, p;
    neg = (a < 0) ^ (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    if (ma > (64'd1 << 34) - 1) ma = (64'd1 << 34) - 1;
    if (mb > (64'd1 << 30) - 1) mb = (64'd1 << 30) - 1;
    p = (ma * mb + (64'd1 << 29)) >> 30;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint term_coef(int idx, int term);
    return term[0] ? -longint'(fact_tab[idx]) : longint'(fact_tab[idx]);
  endfunction

  // Expected value for one word: reduce to [-pi, pi), then Horner sum.
  function automatic logic signed [31:0] trig_value(logic cmd, logic signed [31:0] ang);
    longint s, k, z, y, w, acc;
    s = longint'(ang) * (64'sd1 <<< 20) + PI44;
    k = s / TPI44;
    if (s % TPI44 < 0) k = k - 1;
    z = s - k * TPI44 - PI44;
    y = longint'((64'(z) + (64'd1 << 61) + (64'd1 << 15)) >> 16) - (64'sd1 <<< 45);
    w = mul_q30(y, y);
    if (cmd == CMD_SINE) begin
      acc = term_coef(2*(TERMS-1)+1, TERMS-1);
      for (int i = TERMS-2; i >= 0; i--) acc = term_coef(2*i+1, i) + mul_q30(acc, w);
      acc = mul_q30(acc, y);
    end else begin
      acc = term_coef(2*(TERMS-1), TERMS-1);
      for (int i = TERMS-2; i >= 0; i--) acc = term_coef(2*i, i) + mul_q30(acc, w);
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  int fail_count;

  task automatic report_mismatch(string what);
    $display("ERROR %0t: %s", $time, what);
    fail_count++;
  endtask

  // Scoreboard of pending trig values.
  class trig_scoreboard;
    logic signed [31:0] pending_values[$];
    function void note_word(logic cmd, logic signed [31:0] ang);
      pending_values.push_back(trig_value(cmd, ang));
    endfunction
    task check_word(logic signed [31:0] got);
      logic signed [31:0] want;
      if (pending_values.size() == 0) begin
        report_mismatch($sformatf("unexpected word value=%0d", got));
        return;
      end
      want = pending_values.pop_front();
      if (got !== want)
        report_mismatch($sformatf("value got %0d want %0d", got, want));
    endtask
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, command_i;
  logic signed [31:0] angle_i;
  logic out_valid_o, out_ready_i;
  logic signed [31:0] value_o;

  sine_cosine_taylor_unit uut (.*);

  trig_scoreboard sb;
  logic calm_phase, hold_rx, stim_done;
  int idle_cycles;

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // Send one word, holding valid until accepted.
  task automatic send_word(logic cmd, logic signed [31:0] ang);
    int gap;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    angle_i    <= ang;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 32'h0700_0000))) - 32'sh0380_0000;
      2: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return 32'h3243_F6A9 * $urandom_range(0, 8) - $urandom_range(0, 3);
    endcase
  endfunction

  // Accept records and check outputs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_word(command_i, angle_i);
      if (out_valid_o && out_ready_i) sb.check_word(value_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stall bursts, a long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        out_ready_i <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_rx = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCH_LIM) begin
      $display("sine_cosine_taylor_unit regression: fail");
      $finish;
    end
  end

  logic signed [31:0] edge_angles [12] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0,
    32'shFFFF_FFFF, 32'sh1, 32'sh0324_3F6A, 32'shFCDB_C096, 32'shFCDB_C095,
    32'sh0192_1FB5, 32'sh0648_7ED5, 32'sh5555_5555, 32'shAAAA_AAAA};

  initial begin
    sb = new();
    build_fact_tab();
    fail_count = 0;
    idle_cycles = 0;
    calm_phase = 1'b0;
    hold_rx = 1'b0;
    stim_done = 1'b0;
    in_valid_i = 1'b0;
    command_i = 1'b0;
    angle_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed extremes for both functions.
    foreach (edge_angles[i]) begin
      send_word(CMD_SINE, edge_angles[i]);
      send_word(CMD_COSINE, edge_angles[i]);
    end
    drop_valid();
    // Pause until everything has drained.
    while (sb.pending_values.size() != 0) @(posedge clk_i);

    // Receiver holds off while words keep coming, filling the pipe.
    hold_rx = 1'b1;
    for (int i = 0; i < 40; i++) send_word($urandom_range(0, 1), rand_angle());

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 300) calm_phase = 1'b1;
      send_word($urandom_range(0, 1), rand_angle());
    end
    drop_valid();

    while (sb.pending_values.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sine_cosine_taylor_unit regression: pass");
    end else begin
      $display("sine_cosine_taylor_unit regression: fail");
    end
    $finish;
  end

endmodule
